// ===== rtl/estq_pkg.sv =====
// Shared types and constants for the ECG sample quality tagger.
// Used by the channel interfaces and every module in rtl/.
package estq_pkg;

   localparam int ADC_W        = 32;
   localparam int STAMP_W      = 32;
   localparam int EXP_W        = 8;
   localparam int ZCOUNT_W     = 16;
   localparam int COUNT_W      = 32;
   localparam int FLAG_W       = 6;
   localparam int LEAD_EVT_W   = 2;
   localparam int SLOT_OUT_W   = 10;
   localparam int CSR_INDEX_W  = 8;
   localparam int CSR_DATA_W   = 32;

   localparam int BANK_DEPTH_DEFAULT = 1024;
   localparam int BANK_COUNT_DEFAULT = 2;

   localparam int FLAG_ADC_ERR   = 0;
   localparam int FLAG_ZERO_RUN  = 1;
   localparam int FLAG_EXP_ERR   = 2;
   localparam int FLAG_TIMEOUT   = 3;
   localparam int FLAG_RESTARTED = 4;
   localparam int FLAG_NEW_LOG   = 5;

   localparam logic [EXP_W-1:0] LEAD_BITS = 8'b0000_0011;

   localparam logic [LEAD_EVT_W-1:0] LEAD_NONE = 2'd0;
   localparam logic [LEAD_EVT_W-1:0] LEAD_OFF  = 2'd1;
   localparam logic [LEAD_EVT_W-1:0] LEAD_BACK = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_ADC_INVALID = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXP_INVALID = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO_LIMIT  = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAP_LIMIT   = 8'd3;

   localparam logic [ADC_W-1:0]    ADC_INVALID_RESET = 32'h8000_0000;
   localparam logic [EXP_W-1:0]    EXP_INVALID_RESET = 8'hFF;
   localparam logic [ZCOUNT_W-1:0] ZERO_LIMIT_RESET  = 16'd1000;
   localparam logic [STAMP_W-1:0]  GAP_LIMIT_RESET   = 32'd10;

   typedef struct packed {
      logic [ADC_W-1:0]    adc_invalid_code;
      logic [EXP_W-1:0]    expander_invalid_code;
      logic [ZCOUNT_W-1:0] zero_run_limit;
      logic [STAMP_W-1:0]  gap_limit;
   } cfg_type;

endpackage

// ===== rtl/estq_ifs.sv =====
// Valid/ready channel interfaces: sample request, tagged result, register write.
// Depends on estq_pkg for field widths.
interface estq_req_if import estq_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [ADC_W-1:0] adc_value;
   logic [STAMP_W-1:0]      stamp;
   logic [EXP_W-1:0]        expander_byte;
   logic                    restart_event;
   logic                    new_log_event;

   modport source (output valid, adc_value, stamp, expander_byte, restart_event,
                   new_log_event, input ready);
   modport sink (input valid, adc_value, stamp, expander_byte, restart_event,
                 new_log_event, output ready);
endinterface

interface estq_rsp_if import estq_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [COUNT_W-1:0]      sample_number;
   logic [FLAG_W-1:0]       flag_bits;
   logic                    reinit_request;
   logic [LEAD_EVT_W-1:0]   lead_event;
   logic                    bank_select;
   logic [SLOT_OUT_W-1:0]   bank_slot;
   logic                    bank_done;

   modport source (output valid, sample_number, flag_bits, reinit_request, lead_event,
                   bank_select, bank_slot, bank_done, input ready);
   modport sink (input valid, sample_number, flag_bits, reinit_request, lead_event,
                 bank_select, bank_slot, bank_done, output ready);
endinterface

interface estq_csr_if import estq_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/ecg_sample_quality_tagger_core.sv =====
// ECG sample quality tagger, top level: register bank plus tagging core.
// Depends on estq_pkg, estq_ifs, estq_csr and estq_core.
// A result word is registered and valid in the cycle after its sample word is accepted.
// Throughput: one sample word per cycle unless the result word is stalled; the result register frees on the take.
// Reset (synchronous): counters, pointers and run count clear, first mark set,
// restart note pending, registers to defaults, no result valid.
module ecg_sample_quality_tagger_core import estq_pkg::*; #(
   parameter int BANK_DEPTH = BANK_DEPTH_DEFAULT,
   parameter int BANK_COUNT = BANK_COUNT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   estq_req_if.sink    req_if,
   estq_rsp_if.source  rsp_if,
   estq_csr_if.sink    csr_if
);

   cfg_type cfg;

   estq_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg)
   );

   estq_core #(
      .BANK_DEPTH (BANK_DEPTH),
      .BANK_COUNT (BANK_COUNT)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

endmodule

// ===== rtl/estq_csr.sv =====
// Configuration register bank for the sample quality tagger.
// Depends on estq_pkg and estq_csr_if.
module estq_csr import estq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   estq_csr_if.sink    csr_if,
   output cfg_type     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_fire;

   assign csr_if.ready = 1'b1;
   assign wr_fire      = csr_if.valid && csr_if.ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_fire) begin
         case (csr_if.index)
            CSR_ADC_INVALID: cfg_in.adc_invalid_code      = csr_if.data[ADC_W-1:0];
            CSR_EXP_INVALID: cfg_in.expander_invalid_code = csr_if.data[EXP_W-1:0];
            CSR_ZERO_LIMIT:  cfg_in.zero_run_limit        = csr_if.data[ZCOUNT_W-1:0];
            CSR_GAP_LIMIT:   cfg_in.gap_limit             = csr_if.data[STAMP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.adc_invalid_code      <= ADC_INVALID_RESET;
         cfg_ff.expander_invalid_code <= EXP_INVALID_RESET;
         cfg_ff.zero_run_limit        <= ZERO_LIMIT_RESET;
         cfg_ff.gap_limit             <= GAP_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/estq_core.sv =====
// Per-sample tagging: flag logic, run/gap/lead state, bank pointers, result register.
// Depends on estq_pkg, estq_req_if and estq_rsp_if.
module estq_core import estq_pkg::*; #(
   parameter int BANK_DEPTH = BANK_DEPTH_DEFAULT,
   parameter int BANK_COUNT = BANK_COUNT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   estq_req_if.sink    req_if,
   estq_rsp_if.source  rsp_if
);

   localparam int SlotW = $clog2(BANK_DEPTH);
   localparam int BankW = $clog2(BANK_COUNT);
   localparam logic [SlotW-1:0] SlotLast = SlotW'(BANK_DEPTH - 1);
   localparam logic [BankW-1:0] BankLast = BankW'(BANK_COUNT - 1);

   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [ZCOUNT_W-1:0] zcount_ff, zcount_in;
   logic [STAMP_W-1:0]  last_stamp_ff, last_stamp_in;
   logic                first_ff, first_in;
   logic                leads_off_ff, leads_off_in;
   logic [1:0]          pending_ff, pending_in;
   logic [SlotW-1:0]    slot_ff, slot_in;
   logic [BankW-1:0]    bank_ff, bank_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]    num_ff;
   logic [FLAG_W-1:0]     flags_ff, flags_in;
   logic                  reinit_ff, reinit_in;
   logic [LEAD_EVT_W-1:0] lead_ff, lead_in;
   logic                  bsel_ff;
   logic [SLOT_OUT_W-1:0] bslot_ff;
   logic                  done_ff, done_in;

   logic                req_fire;
   logic [STAMP_W-1:0]  gap;
   logic [ZCOUNT_W-1:0] zcount_step;
   logic                lead_now;
   logic                leads_prev;
   logic [31:0]         slot_wide;
   logic [31:0]         bank_wide;

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_fire     = req_if.valid && req_if.ready;

   assign gap       = req_if.stamp - last_stamp_ff;
   assign lead_now  = |(req_if.expander_byte & LEAD_BITS);
   assign slot_wide = 32'(slot_ff);
   assign bank_wide = 32'(bank_ff);
   assign done_in   = (slot_ff == SlotLast);

   always_comb begin
      flags_in = '0;
      flags_in[FLAG_RESTARTED] = pending_ff[0] | req_if.restart_event;
      flags_in[FLAG_NEW_LOG]   = pending_ff[1] | req_if.new_log_event;
      flags_in[FLAG_ADC_ERR]   = (req_if.adc_value == cfg.adc_invalid_code);
      flags_in[FLAG_EXP_ERR]   = (req_if.expander_byte == cfg.expander_invalid_code);
      flags_in[FLAG_TIMEOUT]   = (gap > cfg.gap_limit) && !first_ff;

      if (req_if.adc_value == '0) begin
         zcount_step = (zcount_ff == '1) ? zcount_ff : zcount_ff + 1'b1;
      end else begin
         zcount_step = '0;
      end
      flags_in[FLAG_ZERO_RUN] = (zcount_step > cfg.zero_run_limit);

      reinit_in  = |flags_in[FLAG_TIMEOUT:FLAG_ADC_ERR];
      leads_prev = reinit_in ? 1'b0 : leads_off_ff;

      if (lead_now) begin
         lead_in = leads_prev ? LEAD_NONE : LEAD_OFF;
      end else begin
         lead_in = leads_prev ? LEAD_BACK : LEAD_NONE;
      end
   end

   always_comb begin
      count_in      = count_ff;
      zcount_in     = zcount_ff;
      last_stamp_in = last_stamp_ff;
      first_in      = first_ff;
      leads_off_in  = leads_off_ff;
      pending_in    = pending_ff;
      slot_in       = slot_ff;
      bank_in       = bank_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      if (req_fire) begin
         count_in      = count_ff + 1'b1;
         zcount_in     = reinit_in ? '0 : zcount_step;
         last_stamp_in = req_if.stamp;
         first_in      = reinit_in;
         leads_off_in  = lead_now;
         pending_in    = '0;
         rsp_valid_in  = 1'b1;
         if (done_in) begin
            slot_in = '0;
            bank_in = (bank_ff == BankLast) ? '0 : bank_ff + 1'b1;
         end else begin
            slot_in = slot_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         zcount_ff     <= '0;
         last_stamp_ff <= '0;
         first_ff      <= 1'b1;
         leads_off_ff  <= 1'b0;
         pending_ff    <= 2'b01;
         slot_ff       <= '0;
         bank_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         zcount_ff     <= zcount_in;
         last_stamp_ff <= last_stamp_in;
         first_ff      <= first_in;
         leads_off_ff  <= leads_off_in;
         pending_ff    <= pending_in;
         slot_ff       <= slot_in;
         bank_ff       <= bank_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         num_ff    <= count_ff;
         flags_ff  <= flags_in;
         reinit_ff <= reinit_in;
         lead_ff   <= lead_in;
         bsel_ff   <= bank_wide[0];
         bslot_ff  <= slot_wide[SLOT_OUT_W-1:0];
         done_ff   <= done_in;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.sample_number  = num_ff;
   assign rsp_if.flag_bits      = flags_ff;
   assign rsp_if.reinit_request = reinit_ff;
   assign rsp_if.lead_event     = lead_ff;
   assign rsp_if.bank_select    = bsel_ff;
   assign rsp_if.bank_slot      = bslot_ff;
   assign rsp_if.bank_done      = done_ff;

   a_fire_gives_word: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("accepted sample produced no result word");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_if.ready) |-> !req_if.ready)
      else $error("input accepted while result word stalled");

   a_error_clears: assert property (@(posedge clock) disable iff (reset)
      (req_fire && reinit_in) |=> (zcount_ff == '0) && first_ff)
      else $error("error did not clear zero count and first mark");

   a_notes_cleared: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (pending_ff == 2'b00))
      else $error("held notes survived a sample");

   a_number_tracks: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (num_ff == $past(count_ff)) && (count_ff == num_ff + 1'b1))
      else $error("sample number out of step with counter");

endmodule
